@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Clocked on clock, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`endif

@@ design/bpc_pkg.sv @@
// Package for the barometric pressure compensation block.
// Types, opcodes and constants; no dependencies.
`timescale 1ns / 1ps
package bpc_pkg;
   localparam logic OP_TEMP  = 1'b0;
   localparam logic OP_PRESS = 1'b1;

   localparam logic [1:0] REG_CAL_A = 2'd0;
   localparam logic [1:0] REG_CAL_B = 2'd1;
   localparam logic [1:0] REG_CAL_C = 2'd2;
   localparam logic [1:0] REG_OSS   = 2'd3;

   localparam logic [31:0] B6_OFFSET = 32'd4000;
   localparam logic [31:0] B4_BIAS   = 32'd32768;
   localparam logic [31:0] B7_SCALE  = 32'd50000;
   localparam logic [31:0] P_K1      = 32'd3038;
   localparam logic [31:0] P_K2      = 32'd7357;
   localparam logic [31:0] P_K3      = 32'd3791;

   typedef struct packed {
      logic        start;
      logic        is_unsigned;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage

@@ design/bpc_if.sv @@
// Valid/ready channel interfaces for the compensation block.
// Depends on nothing.
`timescale 1ns / 1ps
interface bpc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [23:0] raw_reading;
   modport source (output valid, opcode, raw_reading, input ready);
   modport sink   (input valid, opcode, raw_reading, output ready);
endinterface

interface bpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic signed [31:0] result_value;
   logic        status;
   modport source (output valid, result_kind, result_value, status, input ready);
   modport sink   (input valid, result_kind, result_value, status, output ready);
endinterface

interface bpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/bpc_div.sv @@
// Restoring divider, one quotient bit per cycle, signed or unsigned 32-bit.
// Uses bpc_pkg request/response structs.
`timescale 1ns / 1ps
module bpc_div (
   input  logic               clock,
   input  logic               reset,
   input  bpc_pkg::div_req_type req,
   output bpc_pkg::div_rsp_type rsp
);
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic        neg_ff, neg_in, done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] a_mag, b_mag;

   always_comb begin
      a_mag = (!req.is_unsigned && req.dividend[31]) ? 32'(-req.dividend) : req.dividend;
      b_mag = (!req.is_unsigned && req.divisor[31]) ? 32'(-req.divisor) : req.divisor;
      trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = 6'd0;
         rem_in = '0;
         quo_in = a_mag;
         dvs_in = b_mag;
         neg_in = !req.is_unsigned && (req.dividend[31] ^ req.divisor[31]);
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = neg_ff ? 32'(-quo_ff) : quo_ff;
endmodule

@@ design/barometric_pressure_compensation.sv @@
// Top level: barometric pressure compensation with a shared multiplier and divider.
// Depends on bpc_pkg, bpc_if and bpc_div.
//
// Usage:
//  csr channel writes calibration words (index 0..2) and oversampling (3);
//  write only while idle. csr_ready is always high.
//  req channel takes one transaction: opcode 0 temperature, 1 pressure.
//  rsp channel returns exactly one transaction per request, in order.
//  Both paths use the bit-serial divider, with one multiply step
//  per cycle on the shared 32x32 multiplier. A zero divisor skips the
//  divider. One request is in flight at a time; req_ready is low from
//  acceptance until the response is taken.
//  A stalled receiver holds the response steady in the output register.
//  Synchronous reset clears the sequencer, the calibration registers, rsp_valid and stored b5.
//  Temperature with zero divisor reports status 1 and keeps old b5.
`timescale 1ns / 1ps
module barometric_pressure_compensation (
   input logic       clock,
   input logic       reset,
   bpc_req_if.sink   req,
   bpc_rsp_if.source rsp,
   bpc_csr_if.sink   csr
);
   typedef enum logic [4:0] {
      S_IDLE, S_T1, S_T2, S_TDIV, S_TWAIT, S_TEND,
      S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_PDIV, S_PWAIT,
      S_P9, S_P10, S_P11, S_P12, S_OUT
   } state_type;

   state_type   state_ff;
   logic [63:0] cal_a_ff, cal_b_ff;
   logic [47:0] cal_c_ff;
   logic [1:0]  oss_ff;
   logic [31:0] b5_ff;
   logic        kind_ff;
   logic [23:0] raw_ff;
   logic [31:0] r0_ff, r1_ff, r2_ff, r3_ff, b3_ff, b4_ff, b7_ff;
   logic [31:0] val_ff;
   logic        stat_ff, rv_ff;
   logic [31:0] ma, mb, prod;
   bpc_pkg::div_req_type dreq;
   bpc_pkg::div_rsp_type drsp;

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = 32'(signed'(cal_a_ff[15:0]));
   assign ac2 = 32'(signed'(cal_a_ff[31:16]));
   assign ac3 = 32'(signed'(cal_a_ff[47:32]));
   assign ac4 = {16'd0, cal_a_ff[63:48]};
   assign ac5 = {16'd0, cal_b_ff[15:0]};
   assign ac6 = {16'd0, cal_b_ff[31:16]};
   assign b1  = 32'(signed'(cal_b_ff[47:32]));
   assign b2  = 32'(signed'(cal_b_ff[63:48]));
   assign mc  = 32'(signed'(cal_c_ff[31:16]));
   assign md  = 32'(signed'(cal_c_ff[47:32]));

   function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
      asr = 32'($signed(v) >>> s);
   endfunction

   assign prod = ma * mb;
   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.result_kind = kind_ff;
   assign rsp.result_value = val_ff;
   assign rsp.status = stat_ff;

   bpc_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      ma = r0_ff;
      mb = r1_ff;
      dreq = '0;
      case (state_ff)
         S_T1:  begin ma = 32'(raw_ff[15:0]) - ac6; mb = ac5; end
         S_P1:  begin ma = r0_ff; mb = r0_ff; end
         S_P2:  begin ma = b2;  mb = r1_ff; end
         S_P3:  begin ma = ac2; mb = r0_ff; end
         S_P4:  begin ma = ac3; mb = r0_ff; end
         S_P5:  begin ma = b1;  mb = r1_ff; end
         S_P6:  begin ma = ac4; mb = r2_ff + bpc_pkg::B4_BIAS; end
         S_P7:  begin ma = 32'(raw_ff >> (4'd8 - {2'b0, oss_ff})) - b3_ff;
                      mb = bpc_pkg::B7_SCALE >> oss_ff; end
         S_P9:  begin ma = r1_ff; mb = r1_ff; end
         S_P10: begin ma = r1_ff; mb = bpc_pkg::P_K1; end
         S_P11: begin ma = bpc_pkg::P_K2; mb = r0_ff; end
         default: ;
      endcase
      if (state_ff == S_TDIV) begin
         dreq.start = 1'b1;
         dreq.is_unsigned = 1'b0;
         dreq.dividend = mc << 11;
         dreq.divisor = r1_ff;
      end else if (state_ff == S_PDIV) begin
         dreq.start = 1'b1;
         dreq.is_unsigned = 1'b1;
         dreq.dividend = b7_ff[31] ? b7_ff : (b7_ff << 1);
         dreq.divisor = b4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         oss_ff <= '0;
         b5_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            case (csr.index)
               bpc_pkg::REG_CAL_A: cal_a_ff <= csr.data;
               bpc_pkg::REG_CAL_B: cal_b_ff <= csr.data;
               bpc_pkg::REG_CAL_C: cal_c_ff <= csr.data[47:0];
               bpc_pkg::REG_OSS:   oss_ff <= csr.data[1:0];
               default: ;
            endcase
         end
         if (rv_ff && rsp.ready) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  kind_ff <= req.opcode;
                  raw_ff <= req.raw_reading;
                  r0_ff <= b5_ff - bpc_pkg::B6_OFFSET;
                  state_ff <= (req.opcode == bpc_pkg::OP_TEMP) ? S_T1 : S_P1;
               end
            end
            S_T1: begin
               r0_ff <= asr(prod, 5'd15);
               r1_ff <= asr(prod, 5'd15) + md;
               state_ff <= S_T2;
            end
            S_T2: begin
               if (r1_ff == '0) begin
                  val_ff <= '0;
                  stat_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_TDIV;
               end
            end
            S_TDIV: state_ff <= S_TWAIT;
            S_TWAIT: if (drsp.done) begin
               r2_ff <= r0_ff + drsp.quotient;
               state_ff <= S_TEND;
            end
            S_TEND: begin
               b5_ff <= r2_ff;
               val_ff <= asr(r2_ff + 32'd8, 5'd4);
               stat_ff <= 1'b0;
               state_ff <= S_OUT;
            end
            S_P1: begin r1_ff <= asr(prod, 5'd12); state_ff <= S_P2; end
            S_P2: begin r2_ff <= asr(prod, 5'd11); state_ff <= S_P3; end
            S_P3: begin
               r3_ff <= r2_ff + asr(prod, 5'd11);
               state_ff <= S_P4;
            end
            S_P4: begin
               b3_ff <= asr((((ac1 << 2) + r3_ff) << oss_ff) + 32'd2, 5'd2);
               r2_ff <= asr(prod, 5'd13);
               state_ff <= S_P5;
            end
            S_P5: begin
               r2_ff <= asr(r2_ff + asr(prod, 5'd16) + 32'd2, 5'd2);
               state_ff <= S_P6;
            end
            S_P6: begin b4_ff <= prod >> 15; state_ff <= S_P7; end
            S_P7: begin b7_ff <= prod; state_ff <= S_P8; end
            S_P8: begin
               if (b4_ff == '0) begin
                  val_ff <= '0;
                  stat_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_PDIV;
               end
            end
            S_PDIV: state_ff <= S_PWAIT;
            S_PWAIT: if (drsp.done) begin
               r0_ff <= b7_ff[31] ? (drsp.quotient << 1) : drsp.quotient;
               r1_ff <= asr(b7_ff[31] ? (drsp.quotient << 1) : drsp.quotient, 5'd8);
               state_ff <= S_P9;
            end
            S_P9:  begin r1_ff <= prod; state_ff <= S_P10; end
            S_P10: begin r2_ff <= asr(prod, 5'd16); state_ff <= S_P11; end
            S_P11: begin r3_ff <= asr(32'd0 - prod, 5'd16); state_ff <= S_P12; end
            S_P12: begin
               val_ff <= r0_ff + asr(r2_ff + r3_ff + bpc_pkg::P_K3, 5'd4);
               stat_ff <= 1'b0;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rv_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ design/bpc_checker.sv @@
// Port-level checker for the compensation block, bound to the top level.
// Depends on assert_macros.svh and the channel interfaces.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_status,
   input logic [31:0] rsp_value
);
   `CHK_IMPL(no_accept_while_rsp, clock, reset, rsp_valid, !req_ready)
   `CHK_NEXT(busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `CHK_NEXT(rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CHK_IMPL(err_zero, clock, reset, rsp_valid && rsp_status, rsp_value == 32'd0)
endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_value(rsp.result_value)
);

@@ tb/sv/tb_barometric_pressure_compensation.sv @@
// Self-checking testbench for barometric_pressure_compensation.
// Drives raw readings through bpc_req_if, checks each response on bpc_rsp_if
// against a local compensation model; depends on bpc_pkg and bpc_if.
`timescale 1ns / 1ps
module tb_barometric_pressure_compensation;
   typedef struct packed {
      logic        opcode;
      logic [23:0] raw;
   } reading_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic        status;
   } comp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpc_req_if req ();
   bpc_rsp_if rsp ();
   bpc_csr_if csr ();

   barometric_pressure_compensation DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   reading_type pending_readings[$];
   comp_type    expected_comps[$];
   int       errors = 0;
   int       idle_cycles = 0;
   bit       drv_pause = 1'b0;
   bit       hold_rsp = 1'b0;
   int       hold_len = 0;

   logic [63:0] cal_a, cal_b, cal_c;
   logic [1:0]  oss;
   logic [31:0] b5_store;

   function automatic logic [31:0] sra(logic [31:0] v, int s);
      return $unsigned($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] sx(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic comp_type compensate(reading_type r);
      comp_type c;
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, den, b5, up, b6, sq, b3, b4, b7, p;
      ac1 = sx(cal_a[15:0]);  ac2 = sx(cal_a[31:16]);
      ac3 = sx(cal_a[47:32]); ac4 = {16'd0, cal_a[63:48]};
      ac5 = {16'd0, cal_b[15:0]}; ac6 = {16'd0, cal_b[31:16]};
      b1 = sx(cal_b[47:32]);  b2 = sx(cal_b[63:48]);
      mc = sx(cal_c[31:16]);  md = sx(cal_c[47:32]);
      c.kind = r.opcode;
      c.value = '0;
      c.status = 1'b0;
      if (r.opcode == bpc_pkg::OP_TEMP) begin
         x1 = sra(({16'd0, r.raw[15:0]} - ac6) * ac5, 15);
         den = x1 + md;
         if (den == 0) begin
            c.status = 1'b1;
         end else begin
            x2 = $unsigned($signed(mc << 11) / $signed(den));
            b5 = x1 + x2;
            b5_store = b5;
            c.value = sra(b5 + 32'd8, 4);
         end
      end else begin
         up = {8'd0, r.raw} >> (8 - oss);
         b6 = b5_store - bpc_pkg::B6_OFFSET;
         sq = sra(b6 * b6, 12);
         x1 = sra(b2 * sq, 11);
         x2 = sra(ac2 * b6, 11);
         x3 = x1 + x2;
         b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
         x1 = sra(ac3 * b6, 13);
         x2 = sra(b1 * sq, 16);
         x3 = sra(x1 + x2 + 32'd2, 2);
         b4 = (ac4 * (x3 + bpc_pkg::B4_BIAS)) >> 15;
         b7 = (up - b3) * (bpc_pkg::B7_SCALE >> oss);
         if (b4 == 0) begin
            c.status = 1'b1;
         end else begin
            if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
            else p = (b7 / b4) << 1;
            x1 = sra(p, 8);
            x1 = x1 * x1;
            x1 = sra(x1 * bpc_pkg::P_K1, 16);
            x2 = sra(32'd0 - bpc_pkg::P_K2 * p, 16);
            p = p + sra(x1 + x2 + bpc_pkg::P_K3, 4);
            c.value = p;
         end
      end
      return c;
   endfunction

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   // request driver
   int drv_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.opcode <= 1'b0;
         req.raw_reading <= '0;
      end else if (!req.valid || req.ready) begin
         if (req.valid && req.ready)
            expected_comps.push_back(compensate({req.opcode, req.raw_reading}));
         if (drv_gap > 0) begin
            drv_gap <= drv_gap - 1;
            req.valid <= 1'b0;
         end else if (!drv_pause && pending_readings.size() > 0) begin
            reading_type r;
            r = pending_readings.pop_front();
            req.valid <= 1'b1;
            req.opcode <= r.opcode;
            req.raw_reading <= r.raw;
            drv_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_len <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_comps.size() == 0) begin
               $display("%0t: unexpected response kind=%0d value=%0d status=%0d", $time,
                        rsp.result_kind, rsp.result_value, rsp.status);
               errors++;
            end else begin
               comp_type e;
               e = expected_comps.pop_front();
               if (e.kind !== rsp.result_kind)
                  begin $display("%0t: kind expected %0d actual %0d", $time, e.kind,
                     rsp.result_kind); errors++; end
               if (e.value !== rsp.result_value)
                  begin $display("%0t: value expected %0d actual %0d", $time,
                     $signed(e.value), rsp.result_value); errors++; end
               if (e.status !== rsp.status)
                  begin $display("%0t: status expected %0d actual %0d", $time, e.status,
                     rsp.status); errors++; end
            end
         end
         if (hold_rsp) rsp.ready <= 1'b0;
         else if (hold_len > 0) begin
            hold_len <= hold_len - 1;
            rsp.ready <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            hold_len <= gap_len();
            rsp.ready <= 1'b0;
         end else rsp.ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr.valid)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("tb_barometric_pressure_compensation: done, errors");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      case (idx)
         bpc_pkg::REG_CAL_A: cal_a = val;
         bpc_pkg::REG_CAL_B: cal_b = val;
         bpc_pkg::REG_CAL_C: cal_c = {16'd0, val[47:0]};
         bpc_pkg::REG_OSS:   oss = val[1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_readings.size() > 0 || req.valid || expected_comps.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // typical factory calibration
   localparam logic [63:0] CAL_A_TYP = {16'd32741, 16'hC7E9, 16'hFBA4, 16'd408};
   localparam logic [63:0] CAL_B_TYP = {16'd4, 16'd6190, 16'd23153, 16'd32757};
   localparam logic [63:0] CAL_C_TYP = {16'd2868, 16'hD4BD, 16'h8000};

   task automatic add_pair(logic [15:0] ut, logic [23:0] up);
      pending_readings.push_back({bpc_pkg::OP_TEMP, 8'($urandom), ut});
      pending_readings.push_back({bpc_pkg::OP_PRESS, up});
   endtask

   initial begin
      logic [63:0] a, b, c;
      csr.valid = 1'b0; csr.index = '0; csr.data = '0;
      cal_a = '0; cal_b = '0; cal_c = '0; oss = '0; b5_store = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero calibration: divide by zero both ways, pressure before temperature
      pending_readings.push_back({bpc_pkg::OP_PRESS, 24'hFFFFFF});
      pending_readings.push_back({bpc_pkg::OP_TEMP, 24'hFFFFFF});
      pending_readings.push_back({bpc_pkg::OP_PRESS, 24'h000000});
      drain();

      write_reg(bpc_pkg::REG_CAL_A, CAL_A_TYP);
      write_reg(bpc_pkg::REG_CAL_B, CAL_B_TYP);
      write_reg(bpc_pkg::REG_CAL_C, CAL_C_TYP);
      write_reg(bpc_pkg::REG_OSS, 2'd0);
      pending_readings.push_back({bpc_pkg::OP_PRESS, 24'h5D2300});
      add_pair(16'd27898, 24'h5D2300);
      add_pair(16'h0000, 24'h000000);
      add_pair(16'hFFFF, 24'hFFFFFF);
      pending_readings.push_back({bpc_pkg::OP_TEMP, 24'hFF0000});
      drain();

      // temperature with md=0, mc=0x1234 and ut=b1 (not ac6), so x1+md is nonzero
      write_reg(bpc_pkg::REG_CAL_C, {16'd0, 16'h1234, 16'd0});
      add_pair(16'd6190, 24'h800000);
      drain();
      write_reg(bpc_pkg::REG_OSS, 2'd3);
      write_reg(bpc_pkg::REG_CAL_C, CAL_C_TYP);
      add_pair(16'd27898, 24'h5D23FF);
      add_pair(16'hFFFF, 24'hFFFFFF);
      drain();
      write_reg(bpc_pkg::REG_CAL_A, {16'hFFFF, 48'h8000_8000_8000});
      write_reg(bpc_pkg::REG_CAL_B, {16'h8000, 16'h8000, 32'hFFFF_FFFF});
      add_pair(16'h0000, 24'hFFFFFF);
      add_pair(16'hFFFF, 24'h000001);
      drain();

      // back-pressure: receiver holds off while sender keeps offering
      write_reg(bpc_pkg::REG_CAL_A, CAL_A_TYP);
      write_reg(bpc_pkg::REG_CAL_B, CAL_B_TYP);
      write_reg(bpc_pkg::REG_OSS, 2'd1);
      hold_rsp = 1'b1;
      for (int i = 0; i < 6; i++) add_pair(16'(27000 + $urandom_range(0, 2000)), 24'($urandom));
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase % 5)
            0: begin a = CAL_A_TYP; b = CAL_B_TYP; c = CAL_C_TYP; end
            1: begin a = '1; b = '1; c = '1; end
            2: begin a = '0; b = rand64(); c = rand64(); end
            default: begin a = rand64(); b = rand64(); c = rand64(); end
         endcase
         write_reg(bpc_pkg::REG_CAL_A, a);
         write_reg(bpc_pkg::REG_CAL_B, b);
         write_reg(bpc_pkg::REG_CAL_C, c);
         write_reg(bpc_pkg::REG_OSS, 2'($urandom));
         for (int i = 0; i < 52; i++) begin
            if ($urandom_range(0, 3) != 0)
               add_pair(($urandom_range(0, 1) == 0) ? 16'(24000 + $urandom_range(0, 8000))
                        : 16'($urandom), 24'($urandom));
            else pending_readings.push_back({1'($urandom), 24'($urandom)});
         end
         if (phase == 4) begin
            while (pending_readings.size() > 0) @(posedge clock);
            drv_pause = 1'b1;
            while (req.valid || expected_comps.size() > 0) @(posedge clock);
            drv_pause = 1'b0;
         end
         drain();
      end

      if (errors == 0) $display("tb_barometric_pressure_compensation: done, clean");
      else $display("tb_barometric_pressure_compensation: done, errors");
      $finish;
   end
endmodule
